// File: hw/rtl/sss_pkg.sv
// Package for the seven-segment scan driver with digit editing.
// Holds the request opcodes, the request struct and the segment decoder.
// No dependencies.
package sss_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned POS_OUT_W = 3;
  localparam int unsigned SEG_W = 8;
  localparam int unsigned CFG_W = 8;

  localparam logic [CFG_W-1:0] BLINK_FRAMES_RESET = 8'd80;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
  localparam logic [POS_OUT_W-1:0] POS_CODE_TOP = 3'd7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK   = 2'd0,
    OP_SELECT = 2'd1,
    OP_INC    = 2'd2
  } opcode_t;

  typedef struct packed {
    logic                valid;
    logic [OPCODE_W-1:0] opcode;
    logic                confirmed;
  } req_t;

  function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'h0: s = 8'h3f;
      4'h1: s = 8'h06;
      4'h2: s = 8'h5b;
      4'h3: s = 8'h4f;
      4'h4: s = 8'h66;
      4'h5: s = 8'h6d;
      4'h6: s = 8'h7d;
      4'h7: s = 8'h07;
      4'h8: s = 8'h7f;
      4'h9: s = 8'h6f;
      4'ha: s = 8'h77;
      4'hb: s = 8'h7c;
      4'hc: s = 8'h39;
      4'hd: s = 8'h5e;
      4'he: s = 8'h79;
      4'hf: s = 8'h71;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// File: hw/rtl/sss_in_reg.sv
// Input register stage of the seven-segment scan driver.
// Captures one request and holds it until the core takes it.
// Depends on sss_pkg.
module sss_in_reg import sss_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic                in_key_confirmed,
  input  logic                take,
  output req_t                req
);

  logic                valid_r, valid_nxt;
  logic [OPCODE_W-1:0] opcode_r;
  logic                confirmed_r;
  logic                load;

  assign in_stall = valid_r && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      opcode_r    <= in_opcode;
      confirmed_r <= in_key_confirmed;
    end
  end

  assign req = '{valid: valid_r, opcode: opcode_r, confirmed: confirmed_r};

endmodule

// File: hw/rtl/sss_core.sv
// Display state, edit logic and result register of the seven-segment scan driver.
// Holds digits, selection, scan position, blink counter and the blink_frames register.
// Depends on sss_pkg.
module sss_core import sss_pkg::*; #(
  parameter int unsigned DIGIT_COUNT = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  input  req_t                 req,
  output logic                 take,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [POS_OUT_W-1:0] out_digit_position,
  output logic [POS_OUT_W-1:0] out_position_code,
  output logic [SEG_W-1:0]     out_segments,
  output logic                 out_blanked
);

  localparam int unsigned PW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int unsigned SW = $clog2(DIGIT_COUNT + 1);
  localparam logic [PW-1:0] POS_LAST = PW'(DIGIT_COUNT - 1);
  localparam logic [SW-1:0] SEL_NONE = SW'(DIGIT_COUNT);

  logic [CFG_W-1:0]   blink_frames_r;
  logic [DIGIT_W-1:0] digit_r   [DIGIT_COUNT];
  logic [DIGIT_W-1:0] digit_nxt [DIGIT_COUNT];
  logic [SW-1:0]      sel_r, sel_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic [CFG_W-1:0]   frame_r, frame_nxt;
  logic               phase_r, phase_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [PW-1:0]      out_pos_r;
  logic [SEG_W-1:0]   out_seg_r;
  logic               out_dark_r;

  logic               slot_free;
  logic               do_tick, do_sel, do_inc;
  logic               dark;
  logic [SEG_W-1:0]   seg;
  logic [CFG_W-1:0]   frame_inc;

  assign slot_free = !out_valid_r || !out_stall;
  assign take      = req.valid && ((req.opcode != OP_TICK) || slot_free);
  assign do_tick   = take && (req.opcode == OP_TICK);
  assign do_sel    = take && (req.opcode == OP_SELECT) && req.confirmed;
  assign do_inc    = take && (req.opcode == OP_INC) && req.confirmed && (sel_r != SEL_NONE);

  assign dark      = !phase_r && (sel_r == SW'(pos_r));
  assign seg       = dark ? '0 : seg_decode(digit_r[pos_r]);
  assign frame_inc = frame_r + 1'b1;

  always_comb begin
    sel_nxt = sel_r;
    if (do_sel) begin
      sel_nxt = (sel_r == SEL_NONE) ? '0 : sel_r + 1'b1;
    end
  end

  for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_digit
    always_comb begin
      digit_nxt[k] = digit_r[k];
      if (do_inc && (sel_r == SW'(k))) begin
        digit_nxt[k] = (digit_r[k] == DIGIT_MAX) ? '0 : digit_r[k] + 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        digit_r[k] <= '0;
      end else begin
        digit_r[k] <= digit_nxt[k];
      end
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    frame_nxt = frame_r;
    phase_nxt = phase_r;
    if (do_tick) begin
      if (pos_r == POS_LAST) begin
        pos_nxt   = '0;
        frame_nxt = frame_inc;
        if (frame_inc >= blink_frames_r) begin
          frame_nxt = '0;
          phase_nxt = !phase_r;
        end
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (do_tick) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_frames_r <= BLINK_FRAMES_RESET;
      sel_r          <= SEL_NONE;
      pos_r          <= '0;
      frame_r        <= '0;
      phase_r        <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        blink_frames_r <= cfg_wr_data;
      end
      sel_r       <= sel_nxt;
      pos_r       <= pos_nxt;
      frame_r     <= frame_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_tick) begin
      out_pos_r  <= pos_r;
      out_seg_r  <= seg;
      out_dark_r <= dark;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_digit_position = POS_OUT_W'(out_pos_r);
  assign out_position_code  = POS_CODE_TOP - POS_OUT_W'(out_pos_r);
  assign out_segments       = out_seg_r;
  assign out_blanked        = out_dark_r;

endmodule

// File: hw/rtl/seven_segment_scan_with_digit_edit.sv
// Top level of the multiplexed seven-segment scan driver with digit editing.
// Instantiates sss_in_reg and sss_core; depends on sss_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall, in_opcode, in_key_confirmed) carries one
//   request per accepted edge: scan tick, select press or increment press.
//   Presses step the selection or add one modulo 10 to the selected digit
//   when confirmed, and give no result. Each scan tick gives one result on
//   the output channel (out_valid/out_stall): position, select-pin code,
//   segment pattern and the blank flag of the driven digit.
//   A tick goes through the input register, then the result register.
//   Throughput: one request per cycle while the output does not stall, set
//   by the state update between the two registers.
//   Reset (rst_n low at a clock edge) clears all digits, deselects, restarts
//   the scan at digit 0 in the blank phase and loads blink_frames with 80.
//   cfg_wr_en/cfg_wr_data write blink_frames. The user must write it only
//   while the block is idle; the block itself does not enforce this.
//   When the receiver stalls, the result holds; presses still drain, and a
//   tick waits in the input register, which then raises in_stall.
module seven_segment_scan_with_digit_edit import sss_pkg::*; #(
  parameter int unsigned DIGIT_COUNT = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OPCODE_W-1:0]  in_opcode,
  input  logic                 in_key_confirmed,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [POS_OUT_W-1:0] out_digit_position,
  output logic [POS_OUT_W-1:0] out_position_code,
  output logic [SEG_W-1:0]     out_segments,
  output logic                 out_blanked,
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_wr_data
);

  req_t req;
  logic take;

  sss_in_reg u_in_reg (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_key_confirmed (in_key_confirmed),
    .take             (take),
    .req              (req)
  );

  sss_core #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .req                (req),
    .take               (take),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_digit_position (out_digit_position),
    .out_position_code  (out_position_code),
    .out_segments       (out_segments),
    .out_blanked        (out_blanked)
  );

endmodule

// File: verif/tb.sv
// Self-checking testbench for the seven-segment scan driver with digit editing.
// Holds a display predictor, stimulus tasks and a result checker; needs sss_pkg
// and the seven_segment_scan_with_digit_edit RTL.
module tb;
  import sss_pkg::*;

  localparam int DIGITS = 6;
  localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;
  localparam logic [DIGIT_W-1:0] DIGIT_TOP = 4'd9;
  localparam int HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [SEG_W-1:0] SEG_FONT [10] = '{
    8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
  };

  typedef struct packed {
    logic [POS_OUT_W-1:0] pos;
    logic [POS_OUT_W-1:0] code;
    logic [SEG_W-1:0]     seg;
    logic                 blank;
  } scan_slot_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [OPCODE_W-1:0]  in_opcode = OP_TICK;
  logic                 in_key_confirmed = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [POS_OUT_W-1:0] out_digit_position;
  logic [POS_OUT_W-1:0] out_position_code;
  logic [SEG_W-1:0]     out_segments;
  logic                 out_blanked;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]     cfg_wr_data = '0;

  logic [DIGIT_W-1:0]   digit_m [DIGITS];
  logic [POS_OUT_W-1:0] sel_m;
  logic [POS_OUT_W-1:0] scan_m;
  logic [7:0]           frame_m;
  logic                 phase_m;
  logic [CFG_W-1:0]     blink_m;

  scan_slot_t   shown_q [$];
  int           error_count = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           hold_seq = 0;
  int           hold_seen = 0;
  int           hold_left = 0;
  int unsigned  cycle_count = 0;

  seven_segment_scan_with_digit_edit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_key_confirmed   (in_key_confirmed),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_digit_position (out_digit_position),
    .out_position_code  (out_position_code),
    .out_segments       (out_segments),
    .out_blanked        (out_blanked),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("seven_segment_scan_with_digit_edit test failed");
      $finish;
    end
  end

  // hold off for a long stretch on request, else stall at random
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH @%0t: %s got %0h expected %0h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    scan_slot_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (shown_q.size() == 0) begin
        report_mismatch("unexpected result, position", out_digit_position, 0);
      end else begin
        want = shown_q.pop_front();
        if (out_digit_position !== want.pos)
          report_mismatch("digit_position", out_digit_position, want.pos);
        if (out_position_code !== want.code)
          report_mismatch("position_code", out_position_code, want.code);
        if (out_segments !== want.seg)
          report_mismatch("segments", out_segments, want.seg);
        if (out_blanked !== want.blank)
          report_mismatch("blanked", out_blanked, want.blank);
      end
    end
  end

  function automatic void reset_display_model();
    foreach (digit_m[k]) digit_m[k] = '0;
    sel_m = POS_OUT_W'(DIGITS);
    scan_m = '0;
    frame_m = '0;
    phase_m = 1'b0;
    blink_m = BLINK_FRAMES_RESET;
  endfunction

  function automatic void predict_request(input logic [OPCODE_W-1:0] op, input logic conf);
    scan_slot_t slot;
    logic dark;
    case (op)
      OP_SELECT: begin
        if (conf) sel_m = (sel_m >= DIGITS) ? '0 : sel_m + 3'd1;
      end
      OP_INC: begin
        if (conf && sel_m < DIGITS)
          digit_m[sel_m] = (digit_m[sel_m] >= DIGIT_TOP) ? '0 : digit_m[sel_m] + 4'd1;
      end
      OP_TICK: begin
        dark = !phase_m && (sel_m == scan_m);
        slot.pos = scan_m;
        slot.code = 3'd7 - scan_m;
        slot.seg = dark ? '0 : SEG_FONT[digit_m[scan_m]];
        slot.blank = dark;
        shown_q.push_back(slot);
        if (scan_m == DIGITS - 1) begin
          scan_m = '0;
          frame_m = frame_m + 8'd1;
          if (frame_m >= blink_m) begin
            frame_m = '0;
            phase_m = ~phase_m;
          end
        end else begin
          scan_m = scan_m + 3'd1;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(input logic [OPCODE_W-1:0] op, input logic conf);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_key_confirmed <= conf;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(op, conf);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (shown_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_blink(input logic [CFG_W-1:0] frames);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= frames;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    blink_m = frames;
  endtask

  task automatic test_directed();
    send_request(OP_INC, 1'b1);
    send_request(OP_RESERVED, 1'b0);
    send_request(OP_RESERVED, 1'b1);
    send_request(OP_SELECT, 1'b0);
    send_request(OP_INC, 1'b0);
    repeat (6) send_request(OP_TICK, 1'b0);
    send_request(OP_SELECT, 1'b1);
    send_request(OP_INC, 1'b1);
    send_request(OP_TICK, 1'b1);
    repeat (6) send_request(OP_SELECT, 1'b1);
    send_request(OP_SELECT, 1'b1);
  endtask

  task automatic test_reset_blink_period();
    repeat (DIGITS * 80) send_request(OP_TICK, 1'b0);
  endtask

  task automatic send_random_request();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) send_request(OP_TICK, 1'($urandom_range(1)));
    else if (roll < 70) send_request(OP_SELECT, 1'b1);
    else if (roll < 90) send_request(OP_INC, 1'b1);
    else if (roll < 97) send_request($urandom_range(1) ? OP_SELECT : OP_INC, 1'b0);
    else send_request(OP_RESERVED, 1'($urandom_range(1)));
  endtask

  task automatic test_random(input logic [CFG_W-1:0] frames, input int count);
    write_blink(frames);
    repeat (count) send_random_request();
  endtask

  task automatic test_backpressure();
    int saved_idle;
    write_blink(8'd3);
    saved_idle = send_idle_pct;
    send_idle_pct = 0;
    hold_seq++;
    repeat (20) send_random_request();
    settle();
    send_idle_pct = saved_idle;
  endtask

  initial begin
    reset_display_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 33;
    recv_idle_pct = 50;
    test_directed();
    test_reset_blink_period();
    test_random(8'd0, 10);
    test_random(8'd255, 10);
    send_idle_pct = 50;
    recv_idle_pct = 33;
    test_random(8'd1, 10);
    test_backpressure();
    test_random(8'd2, 10);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(CFG_W'($urandom_range(3, 254)), 10);
    test_random(8'd1, 10);
    settle();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("seven_segment_scan_with_digit_edit test passed");
    end else begin
      $display("seven_segment_scan_with_digit_edit test failed");
    end
    $finish;
  end

endmodule
